// ===== rtl/wgm_pkg.sv =====
// Shared constants and types for the wildcard glob matcher.
`default_nettype none
package wgm_pkg;

	localparam int PATTERN_MAX = 32;
	localparam int POS_W       = PATTERN_MAX + 1;
	localparam int CHAR_W      = 8;
	localparam int LEN_W       = 6;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_WORDS   = 4;

	localparam logic [CHAR_W-1:0] STAR_CODE  = 8'h2A;
	localparam logic [CHAR_W-1:0] QUERY_CODE = 8'h3F;
	localparam logic [CHAR_W-1:0] NUL_CODE   = 8'h00;

	localparam logic [CFG_IDX_W-1:0] CFG_BYTES_A = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BYTES_B = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BYTES_C = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BYTES_D = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LENGTH  = 3'd4;

	// Decoded pattern: the bytes, one flag bit per pattern position for use, star and query, and position masks
	typedef struct packed {
		logic [PATTERN_MAX-1:0][CHAR_W-1:0] bytes;
		logic [PATTERN_MAX-1:0]             in_use;
		logic [PATTERN_MAX-1:0]             star;
		logic [PATTERN_MAX-1:0]             query;
		logic [POS_W-1:0]                   range;
		logic [POS_W-1:0]                   last_pos;
	} pat_t;

endpackage
`default_nettype wire

// ===== rtl/wgm_if.sv =====
// Valid/ready channels for name characters and match results.
`default_nettype none
interface wgm_char_if;
	logic                       valid;
	logic                       ready;
	logic [wgm_pkg::CHAR_W-1:0] char_code;
	logic                       has_char;
	logic                       last_char;

	modport source (output valid, char_code, has_char, last_char, input ready);
	modport sink (input valid, char_code, has_char, last_char, output ready);
endinterface

interface wgm_result_if;
	logic valid;
	logic ready;
	logic matched;

	modport source (output valid, matched, input ready);
	modport sink (input valid, matched, output ready);
endinterface
`default_nettype wire

// ===== rtl/wgm_pattern.sv =====
// Pattern configuration registers and per-position pattern decode.
`default_nettype none
module wgm_pattern (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [wgm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [wgm_pkg::CFG_DATA_W-1:0] cfg_data,
	output wgm_pkg::pat_t                      pat
);

	logic [wgm_pkg::CFG_WORDS-1:0][wgm_pkg::CFG_DATA_W-1:0] bytes_q;
	logic [wgm_pkg::LEN_W-1:0]                               len_q;
	wgm_pkg::pat_t                                           pat_d;
	wgm_pkg::pat_t                                           pat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_q <= '0;
			len_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wgm_pkg::CFG_BYTES_A: bytes_q[0] <= cfg_data;
				wgm_pkg::CFG_BYTES_B: bytes_q[1] <= cfg_data;
				wgm_pkg::CFG_BYTES_C: bytes_q[2] <= cfg_data;
				wgm_pkg::CFG_BYTES_D: bytes_q[3] <= cfg_data;
				wgm_pkg::CFG_LENGTH:  len_q <= cfg_data[wgm_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		logic [wgm_pkg::LEN_W-1:0]       lim;
		logic [wgm_pkg::PATTERN_MAX-1:0] zero;
		logic                            ok;
		pat_d = '0;
		lim = (len_q > wgm_pkg::LEN_W'(wgm_pkg::PATTERN_MAX)) ?
			wgm_pkg::LEN_W'(wgm_pkg::PATTERN_MAX) : len_q;
		pat_d.bytes = bytes_q;
		for (int i = 0; i < wgm_pkg::PATTERN_MAX; i++) begin
			zero[i] = (pat_d.bytes[i] == wgm_pkg::NUL_CODE);
		end
		// pattern ends at the first zero byte within the length
		for (int i = 0; i < wgm_pkg::PATTERN_MAX; i++) begin
			ok = (wgm_pkg::LEN_W'(i) < lim);
			for (int j = 0; j <= i; j++) begin
				ok = ok & ~zero[j];
			end
			pat_d.in_use[i] = ok;
			pat_d.star[i]   = ok && (pat_d.bytes[i] == wgm_pkg::STAR_CODE);
			pat_d.query[i]  = ok && (pat_d.bytes[i] == wgm_pkg::QUERY_CODE);
		end
		pat_d.range = {pat_d.in_use, 1'b1};
		pat_d.last_pos = {pat_d.in_use, 1'b1} & ~{1'b0, pat_d.in_use};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q <= '{bytes: '0, in_use: '0, star: '0, query: '0,
				range: wgm_pkg::POS_W'(1), last_pos: wgm_pkg::POS_W'(1)};
		end else begin
			pat_q <= pat_d;
		end
	end

	assign pat = pat_q;

endmodule
`default_nettype wire

// ===== rtl/wildcard_glob_matcher.sv =====
// Top level: streaming glob matcher with '*' and '?' over a configured pattern.
// Takes one name character per cycle and gives one match bit for the word
// that ends each name, valid on the result port once that word has passed
// the input register and then the result register; characters that do not
// end a name give no result. The whole update of the active pattern
// positions (compare, advance, star closure) runs in the single stage between
// the input register and the result register, so the rate is one word per
// cycle; input stalls only when a finished result is held and the next name
// end waits behind it. A pattern write takes effect through the config
// and decode registers; write only while no word is in flight.
`default_nettype none
module wildcard_glob_matcher (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [wgm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [wgm_pkg::CFG_DATA_W-1:0] cfg_data,
	wgm_char_if.sink                            chars,
	wgm_result_if.source                        results
);

	wgm_pkg::pat_t pat;

	logic                       valid_s1;
	logic [wgm_pkg::CHAR_W-1:0] char_s1;
	logic                       has_s1;
	logic                       last_s1;

	logic [wgm_pkg::POS_W-1:0] active_q;
	logic                      out_valid_q;
	logic                      matched_q;

	logic                            out_free;
	logic                            advance;
	logic [wgm_pkg::POS_W-1:0]       star_mask;
	logic [wgm_pkg::POS_W-1:0]       cur0;
	logic [wgm_pkg::PATTERN_MAX-1:0] hit;
	logic [wgm_pkg::POS_W-1:0]       nxt;
	logic [wgm_pkg::POS_W-1:0]       cur1;
	logic [wgm_pkg::POS_W-1:0]       fin;
	logic                            match_bit;

	wgm_pattern u_pattern (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pat       (pat)
	);

	// Spread active bits forward through runs of stars: the carry of
	// x + v ripples through each run from its seed.
	function automatic logic [wgm_pkg::POS_W-1:0] close_stars(
		input logic [wgm_pkg::POS_W-1:0] v,
		input logic [wgm_pkg::POS_W-1:0] m
	);
		logic [wgm_pkg::POS_W-1:0] x;
		logic [wgm_pkg::POS_W-1:0] s;
		x = v | m;
		s = x + v;
		return v | ((x ^ s) & m);
	endfunction

	assign out_free    = !out_valid_q || results.ready;
	assign advance     = valid_s1 && (!last_s1 || out_free);
	assign chars.ready = !valid_s1 || advance;

	always_comb begin
		star_mask = {pat.star, 1'b0};
		cur0 = close_stars(active_q & pat.range, star_mask);
		for (int i = 0; i < wgm_pkg::PATTERN_MAX; i++) begin
			hit[i] = cur0[i] && pat.in_use[i] && !pat.star[i] &&
				(pat.query[i] || (pat.bytes[i] == char_s1));
		end
		nxt = {1'b0, cur0[wgm_pkg::PATTERN_MAX-1:0] & pat.star} | {hit, 1'b0};
		cur1 = close_stars(nxt, star_mask);
		fin = has_s1 ? cur1 : cur0;
		match_bit = |(fin & pat.last_pos);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.valid && chars.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1 <= chars.char_code;
			has_s1  <= chars.has_char;
			last_s1 <= chars.last_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= wgm_pkg::POS_W'(1);
		end else if (advance) begin
			active_q <= last_s1 ? wgm_pkg::POS_W'(1) : fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			matched_q <= match_bit;
		end
	end

	assign results.valid   = out_valid_q;
	assign results.matched = matched_q;

	a_clear_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> active_q == wgm_pkg::POS_W'(1))
		else $error("active positions not cleared after name end");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(advance && last_s1))
		else $error("result word without a name end");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!chars.ready |-> valid_s1 && last_s1 && out_valid_q && !results.ready)
		else $error("input stalled without a blocked result");

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for the wildcard glob matcher: directed and random names.
class glob_match_tracker;
	logic [63:0] pat_words[4];
	logic [5:0]  pat_len;
	logic [32:0] active;
	bit          match_due[$];
	int          errors;
	int          words_seen;

	function new();
		for (int i = 0; i < 4; i++)
			pat_words[i] = '0;
		pat_len    = '0;
		active     = 33'd1;
		errors     = 0;
		words_seen = 0;
	endfunction

	function void write_reg(logic [2:0] idx, logic [63:0] data);
		if (idx == wgm_pkg::CFG_LENGTH)
			pat_len = data[5:0];
		else if (idx <= wgm_pkg::CFG_BYTES_D)
			pat_words[idx] = data;
	endfunction

	function logic [7:0] pat_char(int i);
		return pat_words[i >> 3][(i & 7) * 8 +: 8];
	endfunction

	// pattern stops at the first NUL within the clamped length
	function int used_len();
		int n;
		n = (pat_len > wgm_pkg::PATTERN_MAX) ? wgm_pkg::PATTERN_MAX : int'(pat_len);
		for (int i = 0; i < n; i++)
			if (pat_char(i) == wgm_pkg::NUL_CODE)
				return i;
		return n;
	endfunction

	function logic [32:0] star_close(logic [32:0] v, int n);
		for (int i = n + 1; i < 33; i++)
			v[i] = 1'b0;
		for (int i = 0; i < n; i++)
			if (v[i] && pat_char(i) == wgm_pkg::STAR_CODE)
				v[i + 1] = 1'b1;
		return v;
	endfunction

	function void take_word(logic [7:0] c, logic h, logic l);
		int          n;
		logic [32:0] cur;
		logic [32:0] nxt;
		logic [7:0]  p;
		words_seen++;
		n   = used_len();
		cur = star_close(active, n);
		if (h) begin
			nxt = '0;
			for (int i = 0; i < n; i++) begin
				if (cur[i]) begin
					p = pat_char(i);
					if (p == wgm_pkg::STAR_CODE)
						nxt[i] = 1'b1;
					else if (p == wgm_pkg::QUERY_CODE || p == c)
						nxt[i + 1] = 1'b1;
				end
			end
			cur = star_close(nxt, n);
		end
		if (l) begin
			match_due.push_back(cur[n]);
			active = 33'd1;
		end else begin
			active = cur;
		end
	endfunction

	function void check_match(logic m);
		bit e;
		if (match_due.size() == 0) begin
			$display("%0t: result with none due, expected none, actual matched=%0b", $time, m);
			errors++;
		end else begin
			e = match_due.pop_front();
			if (m !== e) begin
				$display("%0t: matched mismatch, expected %0b, actual %0b", $time, e, m);
				errors++;
			end
		end
	endfunction

	function int pending();
		return match_due.size();
	endfunction
endclass

module tb_top;
	localparam int ITEM_TARGET = 1550;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_AFTER  = 500;
	localparam int HOLD_CYCLES = 300;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;

	wgm_char_if   chars_if();
	wgm_result_if res_if();

	wildcard_glob_matcher dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.chars     (chars_if),
		.results   (res_if)
	);

	glob_match_tracker tracker;
	logic [7:0]        name_buf[$];
	int                burst_left;
	int                items_sent;
	int                cycle_count;
	int                hold_left;
	bit                hold_done;
	int                rx_mode;
	int                rx_left;
	logic [31:0]       rx_mask;
	int                rx_idx;

	initial begin
		clk = 1'b0;
		tracker = new();
	end

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// receiver: own stall pattern, plus one long hold-off to back up the input
	always @(negedge clk) begin
		if (!hold_done && tracker.words_seen >= HOLD_AFTER) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_if.ready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_mask = $urandom;
				rx_left = $urandom_range(20, 200);
			end
			rx_left--;
			rx_idx++;
			case (rx_mode)
				0: res_if.ready <= 1'b1;
				1: res_if.ready <= ($urandom_range(0, 3) != 0);
				2: res_if.ready <= rx_mask[rx_idx % 32];
				default: res_if.ready <= 1'($urandom_range(0, 1));
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1)
			tracker.check_match(res_if.matched);
	end

	task automatic cfg_write(input logic [2:0] idx, input logic [63:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		tracker.write_reg(idx, data);
	endtask

	task automatic program_pattern(input logic [63:0] a, input logic [63:0] b,
			input logic [63:0] c, input logic [63:0] d, input logic [5:0] n);
		cfg_write(wgm_pkg::CFG_BYTES_A, a);
		cfg_write(wgm_pkg::CFG_BYTES_B, b);
		cfg_write(wgm_pkg::CFG_BYTES_C, c);
		cfg_write(wgm_pkg::CFG_BYTES_D, d);
		cfg_write(wgm_pkg::CFG_LENGTH, {58'd0, n});
	endtask

	task automatic send_word(input logic [7:0] c, input logic h, input logic l);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				chars_if.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		chars_if.valid     <= 1'b1;
		chars_if.char_code <= c;
		chars_if.has_char  <= h;
		chars_if.last_char <= l;
		do
			@(posedge clk);
		while (chars_if.ready !== 1'b1);
		tracker.take_word(c, h, l);
		if (h || l)
			items_sent++;
	endtask

	// stop offering, wait for every due match bit, then let in-flight words settle
	task automatic drain();
		@(negedge clk);
		chars_if.valid <= 1'b0;
		burst_left = 0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_name(input bit noisy);
		int  k;
		bit  split_end;
		split_end = noisy && ($urandom_range(0, 7) == 0);
		if (name_buf.size() == 0) begin
			send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
			return;
		end
		for (k = 0; k < name_buf.size(); k++) begin
			if (noisy && $urandom_range(0, 11) == 0)
				send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			send_word(name_buf[k], 1'b1, !split_end && k == name_buf.size() - 1);
		end
		if (split_end)
			send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
	endtask

	function automatic logic [7:0] name_char();
		case ($urandom_range(0, 9))
			0, 1, 2: return "a";
			3, 4, 5: return "b";
			6:       return "*";
			7:       return "?";
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [7:0] pattern_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30) return "a";
		if (r < 55) return "b";
		if (r < 75) return wgm_pkg::STAR_CODE;
		if (r < 92) return wgm_pkg::QUERY_CODE;
		if (r < 95) return wgm_pkg::NUL_CODE;
		return 8'($urandom_range(0, 255));
	endfunction

	// kind 0: built to match, 1: one char disturbed, 2: arbitrary
	function automatic void make_name(int kind);
		int         n;
		int         pos;
		logic [7:0] p;
		name_buf.delete();
		if (kind == 2) begin
			repeat ($urandom_range(0, 6))
				name_buf.push_back(name_char());
			return;
		end
		n = tracker.used_len();
		for (int i = 0; i < n; i++) begin
			p = tracker.pat_char(i);
			if (p == wgm_pkg::STAR_CODE)
				repeat ($urandom_range(0, 3))
					name_buf.push_back(name_char());
			else if (p == wgm_pkg::QUERY_CODE)
				name_buf.push_back(8'($urandom_range(0, 255)));
			else
				name_buf.push_back(p);
		end
		if (kind == 1) begin
			pos = $urandom_range(0, name_buf.size());
			if (pos == name_buf.size() || $urandom_range(0, 2) == 0)
				name_buf.insert(pos, name_char());
			else if ($urandom_range(0, 1) == 0)
				name_buf.delete(pos);
			else
				name_buf[pos] = name_char();
		end
	endfunction

	function automatic void set_name(string s);
		name_buf.delete();
		for (int i = 0; i < s.len(); i++)
			name_buf.push_back(s[i]);
	endfunction

	initial begin
		logic [63:0] w[4];
		logic [5:0]  n;
		int          phase;
		int          stop_at;
		int          r;
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = '0;
		cfg_data           = '0;
		chars_if.valid     = 1'b0;
		chars_if.char_code = '0;
		chars_if.has_char  = 1'b0;
		chars_if.last_char = 1'b0;
		res_if.ready       = 1'b0;
		burst_left         = 0;
		items_sent         = 0;
		cycle_count        = 0;
		hold_left          = 0;
		hold_done          = 1'b0;
		rx_left            = 0;
		rx_idx             = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: pattern a*?c
		program_pattern(64'h633F2A61, '0, '0, '0, 6'd4);
		set_name("abc");
		send_name(1'b0);
		set_name("ac");
		send_name(1'b0);
		name_buf.delete();
		send_name(1'b0);
		send_word("a", 1'b1, 1'b0);
		send_word(8'hFF, 1'b0, 1'b0);
		send_word(8'h00, 1'b1, 1'b0);
		send_word("c", 1'b1, 1'b1);
		name_buf = '{8'h61, 8'hFF, 8'h63};
		send_name(1'b0);
		// pattern swapped in the middle of a name
		send_word("a", 1'b1, 1'b0);
		send_word("b", 1'b1, 1'b0);
		drain();
		program_pattern(64'h632A, '0, '0, '0, 6'd2);
		send_word("c", 1'b1, 1'b1);
		drain();
		// NUL inside the length cuts the pattern
		program_pattern(64'h620061, '0, '0, '0, 6'd3);
		set_name("a");
		send_name(1'b0);
		set_name("ab");
		send_name(1'b0);
		drain();
		// length beyond the maximum, all stars
		program_pattern({8{8'h2A}}, {8{8'h2A}}, {8{8'h2A}}, {8{8'h2A}}, 6'd63);
		set_name("xy");
		send_name(1'b0);
		drain();
		program_pattern('1, '1, '1, '1, 6'd32);
		name_buf = '{8'hFF, 8'hFF};
		send_name(1'b0);
		drain();
		cfg_write(wgm_pkg::CFG_LENGTH, 64'd0);
		name_buf.delete();
		send_name(1'b0);
		set_name("q");
		send_name(1'b0);
		drain();

		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			for (int i = 0; i < 4; i++)
				for (int j = 0; j < 8; j++)
					w[i][j * 8 +: 8] = pattern_char();
			r = $urandom_range(0, 99);
			if (r < 70)
				n = 6'($urandom_range(0, 8));
			else if (r < 90)
				n = 6'($urandom_range(9, 32));
			else
				n = 6'($urandom_range(33, 63));
			case (phase % 6)
				1: begin
					for (int i = 0; i < 4; i++)
						w[i] = '1;
					n = 6'd32;
				end
				3: n = 6'd63;
				5: n = 6'd0;
				default: ;
			endcase
			program_pattern(w[0], w[1], w[2], w[3], n);
			stop_at = items_sent + $urandom_range(60, 200);
			while (items_sent < stop_at) begin
				r = $urandom_range(0, 99);
				make_name((r < 55) ? 0 : (r < 80) ? 1 : 2);
				send_name(1'b1);
			end
			drain();
			phase++;
		end

		repeat (8) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end
endmodule
